### design/assert_macros.svh
// Assertion macros used by the controller (aed_ctrl).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on the rising clock edge, disabled while reset is high.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a condition holds in the cycle after each cycle in which a trigger holds.
`define ASSERT_NEXT(lbl, clk, rst, trig, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

### design/aed_pkg.sv
// Package with constants and command types of the AM envelope demodulator.
package aed_pkg;

   localparam logic [15:0] POLE_Q16       = 16'd62915;
   localparam logic [15:0] PEAK_RESET     = 16'd655;
   localparam logic [15:0] LEVEL_MAX      = 16'hFFFF;
   localparam logic [21:0] W_MAX          = 22'h1FFFFF;
   localparam logic [15:0] THRESH_RESET   = 16'd328;
   localparam logic [15:0] DECAY_RESET    = 16'd65208;
   localparam logic [7:0]  HANG_RESET     = 8'd4;
   localparam logic [37:0] ROUND_HALF     = 38'd32768;
   localparam logic signed [23:0] AUDIO_MAX = 24'sd65536;
   localparam logic signed [23:0] AUDIO_MIN = -24'sd65536;

   localparam logic [1:0] REG_THRESHOLD = 2'd0;
   localparam logic [1:0] REG_DECAY     = 2'd1;
   localparam logic [1:0] REG_HANG      = 2'd2;

   typedef struct packed {
      logic take;
      logic square;
      logic load_rad;
      logic root_step;
      logic peak;
      logic decay;
      logic div_step;
      logic filt_mul;
      logic finish;
   } cmd_type;

endpackage

### design/am_envelope_demod_agc.sv
// Top level of the AM envelope demodulator with hang AGC and its register port.
//
// Each input transfer carries one complex sample (req_in_phase, req_quadrature)
// and a flag req_last_of_block. The block returns exactly one rsp_audio
// transfer per sample, in order. A transfer happens at a clock edge where
// valid is high and stall is low.
// One sample is processed at a time: the input is stalled from the accepting
// edge until the result is placed in the output register, and a new sample can
// be taken in the cycle after that. The processing time is set by the
// 16-step square root and the 16-step restoring division, both one bit a cycle.
// If the receiver stalls, the finished result waits in the output register and
// a further sample is still taken and worked on; it completes only once the
// output register is free.
// Registers agc_threshold, decay_factor and hang_blocks lie at byte addresses
// 0, 4 and 8; users must write them only while the block is idle (unchecked).
// Synchronous reset restores register defaults, the peak level of 0.02,
// a zero hang count and a zero filter state.
module am_envelope_demod_agc
   import aed_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_in_phase,
   input  logic signed [15:0] req_quadrature,
   input  logic               req_last_of_block,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [17:0] rsp_audio,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [3:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   logic [15:0] thresh_ff;
   logic [15:0] decay_ff;
   logic [7:0]  hang_ff;
   logic        wr_en;
   cmd_type     cmd;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= THRESH_RESET;
         decay_ff  <= DECAY_RESET;
         hang_ff   <= HANG_RESET;
      end else if (wr_en && (paddr[1:0] == 2'b00)) begin
         unique case (paddr[3:2])
            REG_THRESHOLD: thresh_ff <= pwdata[15:0];
            REG_DECAY:     decay_ff  <= pwdata[15:0];
            REG_HANG:      hang_ff   <= pwdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_THRESHOLD: prdata = {16'd0, thresh_ff};
         REG_DECAY:     prdata = {16'd0, decay_ff};
         REG_HANG:      prdata = {24'd0, hang_ff};
         default:       prdata = 32'd0;
      endcase
   end

   aed_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   aed_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_in_phase      (req_in_phase),
      .req_quadrature    (req_quadrature),
      .req_last_of_block (req_last_of_block),
      .agc_threshold     (thresh_ff),
      .decay_factor      (decay_ff),
      .hang_blocks       (hang_ff),
      .rsp_audio         (rsp_audio)
   );

endmodule

### design/aed_datapath.sv
// Datapath: squares, square root, peak tracker, division and DC-blocking filter.
module aed_datapath
   import aed_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   input  logic signed [15:0] req_in_phase,
   input  logic signed [15:0] req_quadrature,
   input  logic               req_last_of_block,
   input  logic [15:0]        agc_threshold,
   input  logic [15:0]        decay_factor,
   input  logic [7:0]         hang_blocks,
   output logic signed [17:0] rsp_audio
);

   logic signed [15:0] i_ff, q_ff;
   logic               last_ff;
   logic [30:0]        ii_ff, qq_ff;
   logic [31:0]        rad_ff;
   logic [16:0]        rem_ff;
   logic [15:0]        root_ff;
   logic [15:0]        peak_ff;
   logic [7:0]         hang_ff;
   logic [15:0]        div_ff;
   logic               sat_ff;
   logic [15:0]        drem_ff;
   logic [15:0]        quo_ff;
   logic [37:0]        fprod_ff;
   logic [21:0]        prev_ff;
   logic signed [17:0] audio_ff;

   logic signed [31:0] sq_i, sq_q;
   logic [18:0]        rem_t, trial, rem_d;
   logic [15:0]        pk, thr, div_in;
   logic [31:0]        decay_prod;
   logic [16:0]        r2, r2_d;
   logic [15:0]        level;
   logic [22:0]        w;
   logic [21:0]        w_sat;
   logic signed [23:0] diff;
   logic signed [17:0] audio_in;

   always_comb begin
      sq_i       = i_ff * i_ff;
      sq_q       = q_ff * q_ff;
      rem_t      = {rem_ff, rad_ff[31:30]};
      trial      = {1'b0, root_ff, 2'b01};
      rem_d      = rem_t - trial;
      pk         = (peak_ff < root_ff) ? root_ff : peak_ff;
      thr        = (agc_threshold == 16'd0) ? 16'd1 : agc_threshold;
      div_in     = (pk > thr) ? pk : thr;
      decay_prod = peak_ff * decay_factor;
      r2         = {drem_ff, 1'b0};
      r2_d       = r2 - {1'b0, div_ff};
      level      = sat_ff ? LEVEL_MAX : quo_ff;
      w          = {7'd0, level} + {1'b0, fprod_ff[37:16]};
      w_sat      = (w > {1'b0, W_MAX}) ? W_MAX : w[21:0];
      diff       = $signed({2'b00, w_sat}) - $signed({2'b00, prev_ff});
      if (diff > AUDIO_MAX) begin
         audio_in = AUDIO_MAX[17:0];
      end else if (diff < AUDIO_MIN) begin
         audio_in = AUDIO_MIN[17:0];
      end else begin
         audio_in = diff[17:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_ff <= PEAK_RESET;
         hang_ff <= 8'd0;
         prev_ff <= 22'd0;
      end else begin
         if (cmd.peak && (peak_ff < root_ff)) begin
            peak_ff <= root_ff;
            hang_ff <= hang_blocks;
         end
         if (cmd.decay && (hang_ff == 8'd0)) begin
            peak_ff <= decay_prod[31:16];
         end
         if (cmd.finish) begin
            prev_ff <= w_sat;
            if (last_ff && (hang_ff != 8'd0)) begin
               hang_ff <= hang_ff - 8'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         i_ff    <= req_in_phase;
         q_ff    <= req_quadrature;
         last_ff <= req_last_of_block;
      end
      if (cmd.square) begin
         ii_ff <= sq_i[30:0];
         qq_ff <= sq_q[30:0];
      end
      if (cmd.load_rad) begin
         rad_ff  <= {1'b0, ii_ff} + {1'b0, qq_ff};
         rem_ff  <= 17'd0;
         root_ff <= 16'd0;
      end
      if (cmd.root_step) begin
         rad_ff <= {rad_ff[29:0], 2'b00};
         if (rem_t >= trial) begin
            rem_ff  <= rem_d[16:0];
            root_ff <= {root_ff[14:0], 1'b1};
         end else begin
            rem_ff  <= rem_t[16:0];
            root_ff <= {root_ff[14:0], 1'b0};
         end
      end
      if (cmd.peak) begin
         div_ff  <= div_in;
         sat_ff  <= (root_ff >= div_in);
         drem_ff <= root_ff;
         quo_ff  <= 16'd0;
      end
      if (cmd.div_step) begin
         if (r2 >= {1'b0, div_ff}) begin
            drem_ff <= r2_d[15:0];
            quo_ff  <= {quo_ff[14:0], 1'b1};
         end else begin
            drem_ff <= r2[15:0];
            quo_ff  <= {quo_ff[14:0], 1'b0};
         end
      end
      if (cmd.filt_mul) begin
         fprod_ff <= ({16'd0, prev_ff} * {22'd0, POLE_Q16}) + ROUND_HALF;
      end
      if (cmd.finish) begin
         audio_ff <= audio_in;
      end
   end

   assign rsp_audio = audio_ff;

endmodule

### design/aed_ctrl.sv
// Controller state machine that sequences the datapath for one sample at a time.
module aed_ctrl
   import aed_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output cmd_type cmd
);

   `include "assert_macros.svh"

   typedef enum logic [3:0] {
      ST_IDLE, ST_SQR, ST_LOAD, ST_ROOT, ST_PEAK, ST_DECAY, ST_DIV, ST_FILT, ST_DONE
   } state_type;

   state_type  state_ff;
   logic [3:0] cnt_ff;
   logic       rsp_valid_ff;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd           = '0;
      cmd.take      = (state_ff == ST_IDLE) && req_valid;
      cmd.square    = (state_ff == ST_SQR);
      cmd.load_rad  = (state_ff == ST_LOAD);
      cmd.root_step = (state_ff == ST_ROOT);
      cmd.peak      = (state_ff == ST_PEAK);
      cmd.decay     = (state_ff == ST_DECAY);
      cmd.div_step  = (state_ff == ST_DIV);
      cmd.filt_mul  = (state_ff == ST_FILT);
      cmd.finish    = (state_ff == ST_DONE) && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if ((state_ff == ST_DONE) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_SQR;
               end
            end
            ST_SQR: begin
               state_ff <= ST_LOAD;
            end
            ST_LOAD: begin
               cnt_ff   <= 4'd0;
               state_ff <= ST_ROOT;
            end
            ST_ROOT: begin
               cnt_ff <= cnt_ff + 4'd1;
               if (cnt_ff == 4'd15) begin
                  state_ff <= ST_PEAK;
               end
            end
            ST_PEAK: begin
               state_ff <= ST_DECAY;
            end
            ST_DECAY: begin
               cnt_ff   <= 4'd0;
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               cnt_ff <= cnt_ff + 4'd1;
               if (cnt_ff == 4'd15) begin
                  state_ff <= ST_FILT;
               end
            end
            ST_FILT: begin
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   `ASSERT_NEXT(a_accept_busy, clock, reset, req_valid && !req_stall, req_stall, "accept did not start work")
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid, "stalled result was dropped")
   `ASSERT_NEXT(a_done_wait, clock, reset, (state_ff == ST_DONE) && !out_free, state_ff == ST_DONE, "result overwrote a waiting transfer")
   `ASSERT_CLK(a_finish_free, clock, reset, cmd.finish |-> out_free, "finish while output is occupied")

endmodule

### verif/am_envelope_demod_agc_tb.sv
// Self-checking testbench for the AM envelope demodulator with hang AGC.
`timescale 1ns / 100ps

module am_envelope_demod_agc_tb;
   import aed_pkg::*;

   typedef struct packed {
      logic signed [15:0] in_phase;
      logic signed [15:0] quadrature;
      logic               last_of_block;
   } sample_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [15:0] req_in_phase = '0;
   logic signed [15:0] req_quadrature = '0;
   logic               req_last_of_block = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [17:0] rsp_audio;
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic [3:0]         paddr = '0;
   logic [31:0]        pwdata = '0;
   logic [31:0]        prdata;
   logic               pready;

   am_envelope_demod_agc i_dut (.*);

   always #4 clock = ~clock;

   // Predictor state and configuration.
   logic [15:0] thr_cfg, decay_cfg, peak_q;
   logic [7:0]  hang_cfg, hang_q;
   logic [21:0] prev_q;

   sample_type         pending_samples[$];
   logic signed [17:0] expected_audio[$];
   int                 err_count = 0;
   int                 idle_cycles = 0;
   bit                 hold_off = 1'b0;

   function automatic logic [15:0] root32(logic [31:0] v);
      logic [31:0] res, b;
      res = 0;
      b = 32'h4000_0000;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res[15:0];
   endfunction

   function automatic logic signed [17:0] envelope_step(sample_type s);
      logic [31:0] ii, qq, pw;
      logic [15:0] mag, thr, dv, level;
      logic [47:0] lv;
      logic [63:0] fm;
      logic [31:0] w;
      int          a;
      ii = $signed(s.in_phase) * $signed(s.in_phase);
      qq = $signed(s.quadrature) * $signed(s.quadrature);
      mag = root32(ii + qq);
      if (peak_q < mag) begin
         peak_q = mag;
         hang_q = hang_cfg;
      end
      thr = (thr_cfg == 0) ? 16'd1 : thr_cfg;
      dv = (peak_q > thr) ? peak_q : thr;
      lv = {mag, 16'h0} / dv;
      level = (lv > 48'd65535) ? 16'hFFFF : lv[15:0];
      if (hang_q == 0) begin
         pw = peak_q * decay_cfg;
         peak_q = pw[31:16];
      end
      fm = (64'(prev_q) * 64'd62915 + 64'd32768) >> 16;
      w = 32'(level) + fm[31:0];
      if (w > 32'd2097151) w = 32'd2097151;
      a = int'(w) - int'(prev_q);
      if (a > 65536) a = 65536;
      if (a < -65536) a = -65536;
      prev_q = w[21:0];
      if (s.last_of_block && hang_q > 0) hang_q = hang_q - 1;
      return a[17:0];
   endfunction

   task automatic report_mismatch(string what);
      $display("mismatch: %s", what);
      err_count++;
   endtask

   // Driver: predicts each sample at its transfer.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_audio.push_back(envelope_step({req_in_phase, req_quadrature,
                                                    req_last_of_block}));
         end
         if (!req_valid || !req_stall) begin
            if (pending_samples.size() > 0 && $urandom_range(0, 3) != 0) begin
               sample_type s;
               s = pending_samples.pop_front();
               req_valid <= 1'b1;
               req_in_phase <= s.in_phase;
               req_quadrature <= s.quadrature;
               req_last_of_block <= s.last_of_block;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor and receiver stalls.
   int stall_left = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_audio.size() == 0) begin
               report_mismatch("result transfer with no sample pending");
            end else begin
               logic signed [17:0] e;
               e = expected_audio.pop_front();
               if (rsp_audio !== e)
                  report_mismatch($sformatf("audio %0d, predicted %0d", rsp_audio, e));
            end
         end
         if (hold_off) begin
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            case ($urandom_range(0, 19))
               0, 1, 2: stall_left <= $urandom_range(1, 4);
               3:       stall_left <= $urandom_range(20, 120);
               default: ;
            endcase
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles > 20000) begin
            $display("am_envelope_demod_agc_tb: errors");
            $finish;
         end
      end
   end

   task automatic csr_write(logic [1:0] idx, logic [31:0] val);
      @(posedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= {idx, 2'b00}; pwdata <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      case (idx)
         REG_THRESHOLD: thr_cfg = val[15:0];
         REG_DECAY:     decay_cfg = val[15:0];
         REG_HANG:      hang_cfg = val[7:0];
         default: ;
      endcase
   endtask

   task automatic drain();
      while (pending_samples.size() > 0 || req_valid || expected_audio.size() > 0)
         @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   function automatic sample_type rand_sample(int amp);
      sample_type s;
      s.in_phase = $signed(16'($urandom_range(0, 2 * amp) - amp));
      s.quadrature = $signed(16'($urandom_range(0, 2 * amp) - amp));
      s.last_of_block = ($urandom_range(0, 7) == 0);
      return s;
   endfunction

   task automatic queue_random(int n);
      int amp;
      amp = 32767;
      for (int k = 0; k < n; k++) begin
         sample_type s;
         if ($urandom_range(0, 40) == 0) amp = $urandom_range(0, 4) == 0 ? 32767
                                                : $urandom_range(0, 3000);
         s = rand_sample(amp);
         if ($urandom_range(0, 30) == 0) s = {16'($urandom), 16'($urandom), 1'($urandom)};
         pending_samples.push_back(s);
      end
   endtask

   initial begin
      thr_cfg = THRESH_RESET; decay_cfg = DECAY_RESET; hang_cfg = HANG_RESET;
      peak_q = PEAK_RESET; hang_q = 0; prev_q = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      // Directed: extremes, level of one, threshold of zero.
      pending_samples.push_back({16'sh8000, 16'sh8000, 1'b0});
      pending_samples.push_back({16'sh7FFF, 16'sh7FFF, 1'b1});
      pending_samples.push_back({16'sh7FFF, 16'sh8000, 1'b0});
      pending_samples.push_back({16'sh0000, 16'sh0000, 1'b1});
      pending_samples.push_back({16'sh8000, 16'sh0000, 1'b1});
      pending_samples.push_back({16'sh0000, 16'sh7FFF, 1'b1});
      pending_samples.push_back({16'shFFFF, 16'sh0001, 1'b0});
      for (int k = 0; k < 6; k++) pending_samples.push_back({16'sh0000, 16'sh0000, 1'b1});
      drain();
      csr_write(REG_THRESHOLD, 32'd0);
      csr_write(REG_DECAY, 32'd0);
      csr_write(REG_HANG, 32'd0);
      csr_write(2'd3, 32'hFFFF_FFFF);
      pending_samples.push_back({16'sh0001, 16'sh0000, 1'b0});
      pending_samples.push_back({16'sh0001, 16'sh0000, 1'b1});
      pending_samples.push_back({16'sh0003, 16'sh0004, 1'b0});
      pending_samples.push_back({16'sh0000, 16'sh0000, 1'b0});
      drain();
      csr_write(REG_THRESHOLD, 32'd46341);
      csr_write(REG_DECAY, 32'd65535);
      csr_write(REG_HANG, 32'd255);
      queue_random(300);
      drain();
      // Receiver holds off while the sender keeps offering samples.
      hold_off = 1'b1;
      queue_random(20);
      repeat (400) @(posedge clock);
      hold_off = 1'b0;
      drain();
      for (int ph = 0; ph < 4; ph++) begin
         csr_write(REG_THRESHOLD, $urandom_range(1, 46341));
         csr_write(REG_DECAY, ph == 0 ? 32'd0 : $urandom_range(50000, 65535));
         csr_write(REG_HANG, ph == 1 ? 32'd0 : $urandom_range(0, 255));
         queue_random(270);
         drain();
      end
      csr_write(REG_THRESHOLD, THRESH_RESET);
      csr_write(REG_DECAY, DECAY_RESET);
      csr_write(REG_HANG, 32'd1);
      queue_random(50);
      drain();
      if (err_count == 0) begin
         $display("am_envelope_demod_agc_tb: clean");
      end else begin
         $display("am_envelope_demod_agc_tb: errors");
      end
      $finish;
   end

endmodule
